### src/bitonic_sorting_network_unit_assert.svh
// ----------------------------------------------------------------------------
// Bitonic sorting network assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITONIC_SORTING_NETWORK_UNIT_ASSERT_SVH
`define BITONIC_SORTING_NETWORK_UNIT_ASSERT_SVH

// Condition must never hold.
`define BSN_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bsn: forbidden condition seen");

// Antecedent implies consequent in the next cycle.
`define BSN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsn: next-cycle implication failed");

// Antecedent implies consequent in the same cycle.
`define BSN_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsn: same-cycle implication failed");

`endif

### src/bsn_pkg.sv
// ----------------------------------------------------------------------------
// Bitonic sorting network package
// Command type between controller and datapath, fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bsn_pkg;

	// Holds a stage bit index for set sizes up to 2^8.
	localparam int unsigned BIT_W = 3;
	localparam int unsigned DATA_W = 32;

	typedef logic [BIT_W-1:0] bit_sel_t;

	typedef struct packed {
		logic     shift;    // move store down one place, load value at top
		logic     exch;     // run one compare-exchange stage
		logic     flip;     // flip stage, else half-cleaner stage
		bit_sel_t bit_sel;  // top bit of the stage's partner mask
	} dp_cmd_t;

endpackage

`default_nettype wire

### src/bsn_datapath.sv
// ----------------------------------------------------------------------------
// Bitonic sorting network datapath
// Element store as a shift line with one compare-exchange lane per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bsn_datapath
	import bsn_pkg::*;
#(
	parameter int unsigned LOG2_COUNT = 5
) (
	input  wire logic                     clk,
	input  wire dp_cmd_t                  cmd,
	input  wire logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0]      head
);

	localparam int unsigned COUNT = 1 << LOG2_COUNT;

	logic signed [DATA_W-1:0] elem_q [COUNT];
	logic signed [DATA_W-1:0] nxt    [COUNT];

	// Each lane picks its partner for the current stage and keeps max or min.
	always_comb begin
		logic signed [DATA_W-1:0] partner;
		logic                     is_lo;
		for (int i = 0; i < COUNT; i++) begin
			partner = elem_q[i];
			is_lo   = 1'b1;
			for (int k = 0; k < LOG2_COUNT; k++) begin
				if (cmd.bit_sel == BIT_W'(k)) begin
					partner = cmd.flip ? elem_q[i ^ ((2 << k) - 1)] : elem_q[i ^ (1 << k)];
					is_lo   = ((i >> k) & 1) == 0;
				end
			end
			if (is_lo) begin
				nxt[i] = (partner > elem_q[i]) ? partner : elem_q[i];
			end else begin
				nxt[i] = (partner > elem_q[i]) ? elem_q[i] : partner;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < COUNT - 1; i++) begin
				elem_q[i] <= elem_q[i+1];
			end
			elem_q[COUNT-1] <= value;
		end else if (cmd.exch) begin
			for (int i = 0; i < COUNT; i++) begin
				elem_q[i] <= nxt[i];
			end
		end
	end

	assign head = elem_q[0];

endmodule

`default_nettype wire

### src/bsn_ctrl.sv
// ----------------------------------------------------------------------------
// Bitonic sorting network controller
// Sequences load, network stages and drain; drives the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsn_ctrl
	import bsn_pkg::*;
#(
	parameter int unsigned LOG2_COUNT = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic      m_tlast,
	output dp_cmd_t   cmd
);

	localparam int unsigned COUNT = 1 << LOG2_COUNT;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_DRAIN
	} state_t;

	state_t                state_q;
	logic [LOG2_COUNT-1:0] cnt_q;
	bit_sel_t              lvl_q;
	bit_sel_t              bit_q;
	logic                  flip_q;

	logic in_beat;
	logic out_beat;
	logic cnt_end;

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_DRAIN);
	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign cnt_end  = (cnt_q == LOG2_COUNT'(COUNT - 1));
	assign m_tlast  = m_tvalid && cnt_end;

	always_comb begin
		cmd         = '0;
		cmd.shift   = in_beat || out_beat;
		cmd.exch    = (state_q == ST_SORT);
		cmd.flip    = flip_q;
		cmd.bit_sel = flip_q ? lvl_q : bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			lvl_q   <= '0;
			bit_q   <= '0;
			flip_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_end) begin
							state_q <= ST_SORT;
							lvl_q   <= '0;
							flip_q  <= 1'b1;
						end
					end
				end
				ST_SORT: begin
					// Advance: flip, then half-cleaners from lvl-1 down to 0.
					if (flip_q && lvl_q != '0) begin
						flip_q <= 1'b0;
						bit_q  <= lvl_q - 1'b1;
					end else if (!flip_q && bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end else if (lvl_q == BIT_W'(LOG2_COUNT - 1)) begin
						state_q <= ST_DRAIN;
						flip_q  <= 1'b1;
						lvl_q   <= '0;
					end else begin
						lvl_q  <= lvl_q + 1'b1;
						flip_q <= 1'b1;
					end
				end
				ST_DRAIN: begin
					if (out_beat) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_end) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/bitonic_sorting_network_unit.sv
// ----------------------------------------------------------------------------
// Bitonic sorting network unit
// Collects 2^LOG2_COUNT signed values, sorts them largest first, streams out.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one signed 32-bit value per beat. After
//   2^LOG2_COUNT beats the unit stops taking input and runs the network,
//   one compare-exchange stage per cycle across all lanes at once.
//   The master stream then carries the sorted set, largest first, one element
//   per beat, with tlast on the final element. The first result is valid on
//   the cycle after the last stage. A set of N elements takes N load beats,
//   the network stages and N drain beats. While the receiver stalls, the
//   head element holds and nothing advances. Input is taken again once the
//   last sorted beat has gone out.
//   Reset returns the unit to loading with an empty set; the store itself
//   is not cleared and is only read after a full set has been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bitonic_sorting_network_unit
	import bsn_pkg::*;
#(
	parameter int unsigned LOG2_COUNT = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // [31:0] sorted_value
	output logic                   m_tlast    // last
);

	dp_cmd_t                  cmd;
	logic signed [DATA_W-1:0] head;

	bsn_ctrl #(
		.LOG2_COUNT(LOG2_COUNT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tlast (m_tlast),
		.cmd     (cmd)
	);

	bsn_datapath #(
		.LOG2_COUNT(LOG2_COUNT)
	) u_datapath (
		.clk  (clk),
		.cmd  (cmd),
		.value($signed(s_tdata)),
		.head (head)
	);

	assign m_tdata = $unsigned(head);

`include "bitonic_sorting_network_unit_assert.svh"

	`BSN_ASSERT_NEVER(a_no_load_during_drain, s_tready && m_tvalid)
	`BSN_ASSERT_NEVER(a_exch_excludes_shift, cmd.exch && cmd.shift)
	`BSN_ASSERT_NEXT(a_drain_end_reloads, m_tvalid && m_tready && m_tlast, s_tready)
	`BSN_ASSERT_SAME(a_sort_has_no_output, $fell(s_tready), !m_tvalid)

endmodule

`default_nettype wire

### bench/bitonic_sorting_network_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitonic sorting network checker
// Watches both stream channels, collects each loaded set, sorts it through
// its own compare-exchange network and checks every sorted beat in order.
// ----------------------------------------------------------------------------

module bitonic_sorting_network_unit_checker
	import bsn_pkg::*;
#(
	parameter int unsigned LOG2_COUNT = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	input  wire logic              m_tlast,
	output int                     mismatches,
	output int                     pending,
	output int                     beats_checked
);

	localparam int unsigned SET_SIZE = 1 << LOG2_COUNT;

	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct {
		elem_t value;
		logic  last;
	} sorted_beat_t;

	elem_t        set_store [SET_SIZE];
	int unsigned  load_idx;
	int unsigned  out_idx;
	sorted_beat_t sorted_beats [$];

	// Larger value goes to the lower index.
	function automatic void order_pair(input int unsigned lo, input int unsigned hi);
		elem_t held;
		held = set_store[lo];
		if (set_store[hi] > held) begin
			set_store[lo] = set_store[hi];
			set_store[hi] = held;
		end
	endfunction

	function automatic void sort_set();
		int unsigned span;
		int unsigned half;
		int unsigned base;
		int unsigned r;
		int unsigned stride;
		int unsigned i;
		for (span = 2; span <= SET_SIZE; span = span * 2) begin
			half = span / 2;
			// flip stage: mirror pairs within each block
			for (base = 0; base < SET_SIZE; base = base + span)
				for (r = 0; r < half; r++)
					order_pair(base + r, base + span - 1 - r);
			// half-cleaners down to neighbors
			for (stride = half / 2; stride >= 1; stride = stride / 2)
				for (i = 0; i < SET_SIZE; i++)
					if ((i & stride) == 0)
						order_pair(i, i + stride);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sorted_beat_t want;
		int unsigned  k;
		if (!arst_n) begin
			load_idx = 0;
			out_idx = 0;
			sorted_beats.delete();
			mismatches = 0;
			beats_checked = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				set_store[load_idx] = s_tdata;
				if (load_idx == SET_SIZE - 1) begin
					load_idx = 0;
					sort_set();
					for (k = 0; k < SET_SIZE; k++) begin
						want.value = set_store[k];
						want.last = (k == SET_SIZE - 1);
						sorted_beats.push_back(want);
					end
				end else begin
					load_idx++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (sorted_beats.size() == 0) begin
					mismatches++;
					$display("%0t: sorted beat with nothing expected: got %0d last %0b",
						$time, $signed(m_tdata), m_tlast);
				end else begin
					want = sorted_beats.pop_front();
					beats_checked++;
					if (m_tdata !== want.value) begin
						mismatches++;
						$display("%0t: sorted_value at position %0d: expected %0d, got %0d",
							$time, out_idx, want.value, $signed(m_tdata));
					end
					if (m_tlast !== want.last) begin
						mismatches++;
						$display("%0t: last at position %0d: expected %0b, got %0b",
							$time, out_idx, want.last, m_tlast);
					end
					out_idx = want.last ? 0 : out_idx + 1;
				end
			end
			pending = sorted_beats.size();
		end
	end

endmodule

### bench/bitonic_sorting_network_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitonic sorting network testbench
// Loads full sets of signed values (edge values, random, tie-heavy, already
// ordered either way) under random source gaps and sink stalls; the checker
// predicts each sorted run and the verdict comes from its mismatch and pending counts.
// ----------------------------------------------------------------------------

module bitonic_sorting_network_unit_test;
	import bsn_pkg::*;

	localparam int unsigned LOG2_COUNT = 5;
	localparam int unsigned SET_SIZE = 1 << LOG2_COUNT;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_GAP = 12;

	typedef enum {
		SET_DIRECTED,
		SET_RANDOM,
		SET_TIES,
		SET_ASCENDING,
		SET_DESCENDING
	} set_kind_t;

	localparam logic [DATA_W-1:0] EDGE_VALUES [16] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h1234_5678
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;     // [31:0] value
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;          // [31:0] sorted_value
	logic              m_tlast;

	int          mismatches;
	int          pending;
	int          beats_checked;
	int unsigned values_loaded = 0;
	int unsigned sets_loaded = 0;
	int unsigned idle_cycles = 0;
	int unsigned sink_hold = 0;
	bit          sink_burst = 1'b0;
	bit          src_burst = 1'b0;

	logic [DATA_W-1:0] set_vals [SET_SIZE];

	always #5 clk = ~clk;

	bitonic_sorting_network_unit #(
		.LOG2_COUNT(LOG2_COUNT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	bitonic_sorting_network_unit_checker #(
		.LOG2_COUNT(LOG2_COUNT)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.pending      (pending),
		.beats_checked(beats_checked)
	);

	function automatic int unsigned sink_gap();
		// flip between bursts with no stalls and random stalls now and then
		if ($urandom_range(0, 39) == 0)
			sink_burst = ~sink_burst;
		return sink_burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Sink: after each beat hold tready low for a drawn number of cycles;
	// also drop it sometimes while idle so stalls hit the first sorted beat.
	always @(posedge clk or negedge arst_n) begin
		int unsigned gap;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold <= 0;
		end else if (m_tready) begin
			if (m_tvalid || $urandom_range(0, 7) == 0) begin
				gap = sink_gap();
				if (gap != 0) begin
					m_tready <= 1'b0;
					sink_hold <= gap;
				end
			end
		end else if (sink_hold <= 1) begin
			m_tready <= 1'b1;
			sink_hold <= 0;
		end else begin
			sink_hold <= sink_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic build_set(input set_kind_t kind);
		logic [DATA_W-1:0] pool [4];
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] step;
		int unsigned       k;
		for (k = 0; k < 4; k++)
			pool[k] = $urandom;
		start = 32'h8000_0000 + $urandom_range(0, (1 << 26) - 1);
		step = $urandom_range(0, (1 << 26) - 1);
		for (k = 0; k < SET_SIZE; k++) begin
			case (kind)
				SET_DIRECTED:   set_vals[k] = (k < 16) ? EDGE_VALUES[k] : $urandom;
				SET_RANDOM:     set_vals[k] = $urandom;
				SET_TIES:       set_vals[k] = pool[$urandom_range(0, 3)];
				SET_ASCENDING:  set_vals[k] = start + k * step;
				SET_DESCENDING: set_vals[k] = start + (SET_SIZE - 1 - k) * step;
				default:        set_vals[k] = '0;
			endcase
		end
	endtask

	// Leave tvalid high across back-to-back beats; lower it only ahead of a gap.
	task automatic send_value(input logic [DATA_W-1:0] value);
		int unsigned gap;
		gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		values_loaded++;
	endtask

	task automatic send_set(input set_kind_t kind);
		int unsigned k;
		build_set(kind);
		src_burst = ($urandom_range(0, 3) == 0);
		for (k = 0; k < SET_SIZE; k++)
			send_value(set_vals[k]);
		sets_loaded++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_set(SET_DIRECTED);
		send_set(SET_RANDOM);
		send_set(SET_TIES);
		send_set(SET_ASCENDING);
		send_set(SET_DESCENDING);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Loaded %0d values in %0d sets: edge values, random, tie-heavy,",
			values_loaded, sets_loaded);
		$display("ascending and descending order; %0d sorted beats checked.", beats_checked);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/bsn_pkg.sv
src/bsn_datapath.sv
src/bsn_ctrl.sv
src/bitonic_sorting_network_unit.sv
bench/bitonic_sorting_network_unit_checker.sv
bench/bitonic_sorting_network_unit_test.sv
